### rtl/core/rlte_pkg.sv
package rlte_pkg;

	// Fraction range: numerator magnitude and denominator live in signed VW-bit range
	localparam int VW        = 32;
	localparam int MAG_W     = VW;
	localparam int DEN_W     = VW - 1;
	localparam int TOK_W     = 8;
	localparam int PROD_W    = MAG_W + TOK_W;
	localparam int CNT_W     = $clog2(MAG_W);
	localparam int NUM_OUT_W = 32;
	localparam int DEN_OUT_W = 31;

	// Largest positive value of the signed range
	localparam logic [PROD_W-1:0] POS_LIM = (PROD_W'(1) << (VW - 1)) - PROD_W'(1);

	// Token kinds
	localparam logic KIND_NUMBER   = 1'b0;
	localparam logic KIND_OPERATOR = 1'b1;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic             op;
		logic [TOK_W-1:0] value;
	} token_t;

	typedef struct packed {
		logic                        accepted;
		logic signed [NUM_OUT_W-1:0] numerator;
		logic [DEN_OUT_W-1:0]        denominator;
		logic                        overflow;
		logic                        divide_by_zero;
	} result_t;

	// Request to the gcd / reduction unit
	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] mag;
		logic [DEN_W-1:0] den;
	} red_req_t;

	// Reduced fraction back from the unit
	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] mag;
		logic [DEN_W-1:0] den;
	} red_rsp_t;

endpackage

### rtl/core/rlte_reducer.sv
module rlte_reducer (
	input  logic              clk,
	input  logic              arst_n,
	input  rlte_pkg::red_req_t req,
	output rlte_pkg::red_rsp_t rsp
);
	import rlte_pkg::*;

	typedef enum logic [3:0] {
		U_IDLE = 4'b0001,
		U_GCD  = 4'b0010,
		U_DIVA = 4'b0100,
		U_DIVB = 4'b1000
	} u_state_t;

	u_state_t         state_q;
	logic [MAG_W-1:0] a_q;
	logic [MAG_W-1:0] b_q;
	logic [CNT_W-1:0] k_q;
	logic [MAG_W-1:0] g_q;
	logic [MAG_W-1:0] m_q;
	logic [MAG_W-1:0] d_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] qa_q;
	logic             done_q;

	logic [MAG_W:0]   rem_sh;
	logic [MAG_W:0]   sub_x;
	logic [MAG_W:0]   sub_y;
	logic [MAG_W+1:0] diff_full;
	logic [MAG_W:0]   diff;
	logic [MAG_W:0]   neg_diff;
	logic             borrow;
	logic [MAG_W-1:0] rem_nx;
	logic [MAG_W-1:0] quo_nx;
	logic             last;

	// Shared subtractor: a - b during gcd, partial remainder - g during division
	assign rem_sh = {rem_q, quo_q[MAG_W-1]};
	always_comb begin
		if (state_q == U_GCD) begin
			sub_x = {1'b0, a_q};
			sub_y = {1'b0, b_q};
		end else begin
			sub_x = rem_sh;
			sub_y = {1'b0, g_q};
		end
	end
	assign diff_full = {1'b0, sub_x} - {1'b0, sub_y};
	assign diff      = diff_full[MAG_W:0];
	assign borrow    = diff_full[MAG_W+1];
	assign neg_diff  = (~diff) + (MAG_W+1)'(1);

	// Restoring division step
	assign rem_nx = borrow ? rem_sh[MAG_W-1:0] : diff[MAG_W-1:0];
	assign quo_nx = {quo_q[MAG_W-2:0], ~borrow};
	assign last   = (cnt_q == CNT_W'(MAG_W - 1));

	// Sequence: binary gcd, then divide numerator, then denominator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			a_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
			g_q     <= '0;
			m_q     <= '0;
			d_q     <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			qa_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (req.start) begin
						m_q   <= req.mag;
						d_q   <= MAG_W'(req.den);
						a_q   <= req.mag;
						b_q   <= MAG_W'(req.den);
						k_q   <= '0;
						cnt_q <= '0;
						if (req.mag == '0) begin
							// gcd of zero and den is den
							g_q     <= MAG_W'(req.den);
							rem_q   <= '0;
							quo_q   <= req.mag;
							state_q <= U_DIVA;
						end else begin
							state_q <= U_GCD;
						end
					end
				end
				U_GCD: begin
					priority if (a_q == b_q) begin
						g_q     <= a_q << k_q;
						rem_q   <= '0;
						quo_q   <= m_q;
						cnt_q   <= '0;
						state_q <= U_DIVA;
					end else if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + CNT_W'(1);
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (!borrow) begin
						a_q <= diff[MAG_W:1];
					end else begin
						b_q <= neg_diff[MAG_W:1];
					end
				end
				U_DIVA: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q + CNT_W'(1);
					if (last) begin
						qa_q    <= quo_nx;
						rem_q   <= '0;
						quo_q   <= d_q;
						cnt_q   <= '0;
						state_q <= U_DIVB;
					end
				end
				U_DIVB: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q + CNT_W'(1);
					if (last) begin
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.mag  = qa_q;
	assign rsp.den  = DEN_W'(quo_q);

endmodule

### rtl/core/rational_left_to_right_evaluator_core.sv
// Channel   Dir  Handshake                     Word
// token     in   token_valid / token_ready     rlte_pkg::token_t  (op, value)
// result    out  result_valid / result_ready   rlte_pkg::result_t (accepted, fraction, flags)
//
// An operator, a rejected token, a first number or a number after an error goes
// from idle straight to the output state. A folded number takes a multiply, a
// range check, binary gcd steps and 2 x 32 restoring division steps, the last two
// on the one subtractor of the reduction unit, plus the output load.
// arst_n clears the fraction to 0/1, the flags and the sequence.
// token_ready is high only while no token is in work; one result word may wait
// in the output register while the next token is taken.
module rational_left_to_right_evaluator_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              token_valid,
	output logic              token_ready,
	input  rlte_pkg::token_t  token,
	output logic              result_valid,
	input  logic              result_ready,
	output rlte_pkg::result_t result
);
	import rlte_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_FOLD = 5'b00100,
		S_RED  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [MAG_W-1:0]  mag_q;
	logic [DEN_W-1:0]  den_q;
	logic              neg_q;
	op_t               pend_q;
	logic              last_q;
	logic              empty_q;
	logic              ovf_q;
	logic              dbz_q;
	logic [TOK_W-1:0]  n_q;
	logic              ok_q;
	logic [PROD_W-1:0] prod_q;
	logic              start_q;
	logic              res_valid_q;
	result_t           res_q;

	logic              tok_ok;
	logic [MAG_W-1:0]  mul_a;
	logic [PROD_W-1:0] mul_p;
	logic [PROD_W-1:0] mag_x;
	logic [PROD_W-1:0] lim;
	logic [PROD_W-1:0] add_sum;
	logic [PROD_W:0]   sub_d;
	logic              sub_neg;
	logic [PROD_W:0]   sub_mag;
	logic              f_ovf;
	logic [MAG_W-1:0]  f_mag;
	logic [DEN_W-1:0]  f_den;
	logic              f_neg;
	logic              show;
	logic signed [VW-1:0] num_s;
	result_t           res_d;
	logic              out_free;
	red_req_t          req;
	red_rsp_t          rsp;

	// Alternation check
	assign tok_ok = empty_q ? (token.op == KIND_NUMBER) : (token.op != last_q);

	// Multiplier: numerator for multiply, denominator otherwise
	assign mul_a = (pend_q == OP_MUL) ? mag_q : MAG_W'(den_q);
	assign mul_p = mul_a * n_q;

	// Range check and fold of the product into the fraction
	assign mag_x   = PROD_W'(mag_q);
	assign lim     = neg_q ? (POS_LIM + PROD_W'(1)) : POS_LIM;
	assign add_sum = mag_x + prod_q;
	assign sub_d   = {1'b0, mag_x} - {1'b0, prod_q};
	assign sub_neg = sub_d[PROD_W];
	assign sub_mag = sub_neg ? ((~sub_d) + (PROD_W+1)'(1)) : sub_d;

	always_comb begin
		f_ovf = 1'b0;
		f_mag = mag_q;
		f_den = den_q;
		f_neg = neg_q;
		unique case (pend_q)
			OP_ADD, OP_SUB: begin
				if (prod_q > POS_LIM) begin
					f_ovf = 1'b1;
				end else if (neg_q == (pend_q == OP_ADD)) begin
					// signs differ: subtract magnitudes
					f_mag = MAG_W'(sub_mag);
					f_neg = neg_q ^ sub_neg;
				end else if (add_sum > lim) begin
					f_ovf = 1'b1;
				end else begin
					f_mag = MAG_W'(add_sum);
				end
			end
			OP_MUL: begin
				if (prod_q > lim) begin
					f_ovf = 1'b1;
				end else begin
					f_mag = MAG_W'(prod_q);
				end
			end
			OP_DIV: begin
				if (prod_q > POS_LIM) begin
					f_ovf = 1'b1;
				end else begin
					f_den = DEN_W'(prod_q);
				end
			end
			default: begin
				f_ovf = 1'b0;
			end
		endcase
	end

	// Reduction unit
	assign req.start = start_q;
	assign req.mag   = mag_q;
	assign req.den   = den_q;

	rlte_reducer u_reducer (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mag_q   <= '0;
			den_q   <= DEN_W'(1);
			neg_q   <= 1'b0;
			pend_q  <= OP_ADD;
			last_q  <= KIND_NUMBER;
			empty_q <= 1'b1;
			ovf_q   <= 1'b0;
			dbz_q   <= 1'b0;
			n_q     <= '0;
			ok_q    <= 1'b0;
			prod_q  <= '0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (token_valid) begin
						ok_q    <= tok_ok;
						n_q     <= token.value;
						state_q <= S_OUT;
						if (tok_ok && token.op == KIND_OPERATOR) begin
							pend_q <= op_t'(token.value[1:0]);
							last_q <= KIND_OPERATOR;
						end else if (tok_ok) begin
							last_q  <= KIND_NUMBER;
							empty_q <= 1'b0;
							if (empty_q) begin
								mag_q <= MAG_W'(token.value);
								den_q <= DEN_W'(1);
								neg_q <= 1'b0;
							end else if (!ovf_q && !dbz_q) begin
								if (pend_q == OP_DIV && token.value == '0) begin
									dbz_q <= 1'b1;
								end else begin
									state_q <= S_MUL;
								end
							end
						end
					end
				end
				S_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					if (f_ovf) begin
						ovf_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						mag_q   <= f_mag;
						den_q   <= f_den;
						neg_q   <= f_neg;
						start_q <= 1'b1;
						state_q <= S_RED;
					end
				end
				S_RED: begin
					if (rsp.done) begin
						mag_q <= rsp.mag;
						den_q <= rsp.den;
						if (rsp.mag == '0) begin
							neg_q <= 1'b0;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Build the result word from the updated state
	assign show  = !empty_q && (last_q == KIND_NUMBER);
	assign num_s = neg_q ? -$signed(mag_q) : $signed(mag_q);

	always_comb begin
		res_d.accepted       = ok_q;
		res_d.numerator      = show ? NUM_OUT_W'(num_s) : '0;
		res_d.denominator    = show ? DEN_OUT_W'(den_q) : DEN_OUT_W'(1);
		res_d.overflow       = ovf_q;
		res_d.divide_by_zero = dbz_q;
	end

	// Output register: load in the output state when empty or being drained, clear when drained, hold otherwise
	assign out_free = !res_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else if (state_q == S_OUT && out_free) begin
			res_valid_q <= 1'b1;
			res_q       <= res_d;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign token_ready  = (state_q == S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

### rtl/core/rlte_checker.sv
module rlte_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              token_valid,
	input logic              token_ready,
	input rlte_pkg::token_t  token,
	input logic              result_valid,
	input logic              result_ready,
	input rlte_pkg::result_t result
);
	import rlte_pkg::*;

	logic seen_ovf_q;
	logic seen_dbz_q;

	// Track flags already delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_ovf_q <= 1'b0;
			seen_dbz_q <= 1'b0;
		end else if (result_valid && result_ready) begin
			seen_ovf_q <= seen_ovf_q | result.overflow;
			seen_dbz_q <= seen_dbz_q | result.divide_by_zero;
		end
	end

	// Stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// Overflow flag is sticky
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_ovf_q |-> result.overflow)
		else $error("overflow flag dropped");

	// Divide-by-zero flag is sticky
	a_dbz_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_dbz_q |-> result.divide_by_zero)
		else $error("divide_by_zero flag dropped");

	// Zero always reduces to 0/1
	a_zero_red: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.numerator == '0 |-> result.denominator == DEN_OUT_W'(1))
		else $error("zero value not reduced to 0/1");

	// Denominator never zero
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.denominator != '0)
		else $error("zero denominator");

endmodule

bind rational_left_to_right_evaluator_core rlte_checker u_rlte_checker (.*);
